### rtl/rnci_pkg.sv
// ----------------------------------------------------------------------------
// rnci_pkg: shared definitions for the running Newton-Cotes integrator
// Widths, register indexes, microcode field codes, the control word, the
// sequencer program and the Q2.30 Newton-Cotes coefficient table.
// ----------------------------------------------------------------------------
package rnci_pkg;

  // Default widths for the top-level parameters.
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int ACC_WIDTH_DEF    = 64;

  // Fixed datapath widths.
  localparam int MAG_W      = 64;   // magnitude of the wide multiplier operand
  localparam int HALF_W     = 32;   // one partial-product slice
  localparam int PROD_W     = 96;   // full product register
  localparam int COEF_W     = 33;   // signed Q2.30 coefficient, magnitude below 3
  localparam int OUT_W      = 64;   // result width
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int METHOD_W   = 4;
  localparam int PHASE_W    = 4;
  localparam int PC_W       = 4;

  // Product shifts back to Q32.32.
  localparam int SH_TERM = 14;
  localparam int SH_PROD = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_METHOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EVEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd3;

  // Operand A select.
  localparam logic [1:0] A_SAMPLE = 2'd0;
  localparam logic [1:0] A_CHUNK  = 2'd1;
  localparam logic [1:0] A_TOTAL  = 2'd2;

  // Operand B select.
  localparam logic [1:0] B_COEF   = 2'd0;
  localparam logic [1:0] B_COEF0  = 2'd1;
  localparam logic [1:0] B_STEP   = 2'd2;
  localparam logic [1:0] B_SCALE  = 2'd3;

  // Multiplier operation.
  localparam logic [1:0] MUL_NONE = 2'd0;
  localparam logic [1:0] MUL_LO   = 2'd1;
  localparam logic [1:0] MUL_HI   = 2'd2;

  // Product finish: shift and saturation width.
  localparam logic [1:0] FIN_NONE  = 2'd0;
  localparam logic [1:0] FIN_ACC14 = 2'd1;
  localparam logic [1:0] FIN_ACC16 = 2'd2;
  localparam logic [1:0] FIN_OUT16 = 2'd3;

  // Register writeback.
  localparam logic [2:0] WB_NONE      = 3'd0;
  localparam logic [2:0] WB_SUM_ADD   = 3'd1;
  localparam logic [2:0] WB_TOTAL_ADD = 3'd2;
  localparam logic [2:0] WB_OUT       = 3'd3;
  localparam logic [2:0] WB_SUM_LOAD  = 3'd4;

  // Sequencing.
  localparam logic [1:0] SEQ_NEXT         = 2'd0;
  localparam logic [1:0] SEQ_DONE_IF_OPEN = 2'd1;
  localparam logic [1:0] SEQ_WAIT_OUT     = 2'd2;
  localparam logic [1:0] SEQ_DONE         = 2'd3;

  typedef struct packed {
    logic [1:0] a_sel;
    logic [1:0] b_sel;
    logic [1:0] mul_op;
    logic [1:0] fin;
    logic [2:0] wb;
    logic [1:0] seq;
  } ctrl_t;

  // Datapath conditions seen by the sequencer.
  typedef struct packed {
    logic open;      // the current sample does not close its chunk
    logic out_free;  // the output register can take a result this cycle
  } stat_t;

  localparam ctrl_t CTRL_IDLE = '{a_sel: A_SAMPLE, b_sel: B_COEF, mul_op: MUL_NONE,
                                  fin: FIN_NONE, wb: WB_NONE, seq: SEQ_DONE};

  function automatic ctrl_t cw(logic [1:0] a, logic [1:0] b, logic [1:0] m,
                               logic [1:0] f, logic [2:0] w, logic [1:0] s);
    ctrl_t c;
    c.a_sel  = a;
    c.b_sel  = b;
    c.mul_op = m;
    c.fin    = f;
    c.wb     = w;
    c.seq    = s;
    return c;
  endfunction

  // Sequencer program: term, then on a chunk close the total update, the
  // scaled result and the opening term of the next chunk.
  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t c;
    unique case (pc)
      4'd0:  c = cw(A_SAMPLE, B_COEF,  MUL_LO,   FIN_NONE,  WB_NONE,      SEQ_NEXT);
      4'd1:  c = cw(A_SAMPLE, B_COEF,  MUL_HI,   FIN_NONE,  WB_NONE,      SEQ_NEXT);
      4'd2:  c = cw(A_SAMPLE, B_COEF,  MUL_NONE, FIN_ACC14, WB_NONE,      SEQ_NEXT);
      4'd3:  c = cw(A_SAMPLE, B_COEF,  MUL_NONE, FIN_NONE,  WB_SUM_ADD,   SEQ_DONE_IF_OPEN);
      4'd4:  c = cw(A_CHUNK,  B_STEP,  MUL_LO,   FIN_NONE,  WB_NONE,      SEQ_NEXT);
      4'd5:  c = cw(A_CHUNK,  B_STEP,  MUL_HI,   FIN_NONE,  WB_NONE,      SEQ_NEXT);
      4'd6:  c = cw(A_CHUNK,  B_STEP,  MUL_NONE, FIN_ACC16, WB_NONE,      SEQ_NEXT);
      4'd7:  c = cw(A_CHUNK,  B_STEP,  MUL_NONE, FIN_NONE,  WB_TOTAL_ADD, SEQ_NEXT);
      4'd8:  c = cw(A_TOTAL,  B_SCALE, MUL_LO,   FIN_NONE,  WB_NONE,      SEQ_NEXT);
      4'd9:  c = cw(A_TOTAL,  B_SCALE, MUL_HI,   FIN_NONE,  WB_NONE,      SEQ_NEXT);
      4'd10: c = cw(A_TOTAL,  B_SCALE, MUL_NONE, FIN_OUT16, WB_NONE,      SEQ_NEXT);
      4'd11: c = cw(A_TOTAL,  B_SCALE, MUL_NONE, FIN_NONE,  WB_OUT,       SEQ_WAIT_OUT);
      4'd12: c = cw(A_SAMPLE, B_COEF0, MUL_LO,   FIN_NONE,  WB_NONE,      SEQ_NEXT);
      4'd13: c = cw(A_SAMPLE, B_COEF0, MUL_HI,   FIN_NONE,  WB_NONE,      SEQ_NEXT);
      4'd14: c = cw(A_SAMPLE, B_COEF0, MUL_NONE, FIN_ACC14, WB_NONE,      SEQ_NEXT);
      4'd15: c = cw(A_SAMPLE, B_COEF0, MUL_NONE, FIN_NONE,  WB_SUM_LOAD,  SEQ_DONE);
      default: c = CTRL_IDLE;
    endcase
    return c;
  endfunction

  // Closed Newton-Cotes weights in Q2.30, rounded to nearest.
  // m is the number of subintervals (1..8), k the point within the chunk.
  function automatic logic signed [COEF_W-1:0] nc_coef(logic [METHOD_W-1:0] m,
                                                       logic [PHASE_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    logic [PHASE_W-1:0] j;
    c = '0;
    // Every rule is symmetric, so fold the upper half onto the lower.
    j = (k > (m >> 1)) ? PHASE_W'(m - k) : k;
    case (m)
      4'd1: c = 33'sd536870912;
      4'd2: begin
        case (j)
          4'd0:    c = 33'sd357913941;
          default: c = 33'sd1431655765;
        endcase
      end
      4'd3: begin
        case (j)
          4'd0:    c = 33'sd402653184;
          default: c = 33'sd1207959552;
        endcase
      end
      4'd4: begin
        case (j)
          4'd0:    c = 33'sd334053012;
          4'd1:    c = 33'sd1527099483;
          default: c = 33'sd572662306;
        endcase
      end
      4'd5: begin
        case (j)
          4'd0:    c = 33'sd354185671;
          4'd1:    c = 33'sd1398101333;
          default: c = 33'sd932067556;
        endcase
      end
      4'd6: begin
        case (j)
          4'd0:    c = 33'sd314452963;
          4'd1:    c = 33'sd1656630243;
          4'd2:    c = 33'sd207078780;
          default: c = 33'sd2086126972;
        endcase
      end
      4'd7: begin
        case (j)
          4'd0:    c = 33'sd326658609;
          4'd1:    c = 33'sd1555869302;
          4'd2:    c = 33'sd575458509;
          default: c = 33'sd1300109964;
        endcase
      end
      4'd8: begin
        case (j)
          4'd0:    c = 33'sd299662974;
          4'd1:    c = 33'sd1784040031;
          4'd2:    c = -33'sd281180222;
          4'd3:    c = 33'sd3180245273;
          default: c = -33'sd1375601518;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

### rtl/rnci_seq.sv
// ----------------------------------------------------------------------------
// rnci_seq: microcode sequencer
// Step counter over the program in the package; issues one control word per
// cycle and follows the conditional jumps on the datapath status.
// ----------------------------------------------------------------------------
module rnci_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  rnci_pkg::stat_t stat,
  output rnci_pkg::ctrl_t ctrl,
  output logic           busy
);
  import rnci_pkg::*;

  logic [PC_W-1:0] pc;
  ctrl_t           word;

  // Fetch the control word of the current step.
  assign word = ucode(pc);
  assign ctrl = busy ? word : CTRL_IDLE;

  // Step counter and run flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      busy <= 1'b0;
    end else if (!busy) begin
      pc <= '0;
      if (start) begin
        busy <= 1'b1;
      end
    end else begin
      unique case (word.seq)
        SEQ_NEXT: begin
          pc <= pc + PC_W'(1);
        end
        SEQ_DONE_IF_OPEN: begin
          if (stat.open) begin
            pc   <= '0;
            busy <= 1'b0;
          end else begin
            pc <= pc + PC_W'(1);
          end
        end
        SEQ_WAIT_OUT: begin
          if (stat.out_free) begin
            pc <= pc + PC_W'(1);
          end
        end
        SEQ_DONE: begin
          pc   <= '0;
          busy <= 1'b0;
        end
        default: begin
          pc   <= '0;
          busy <= 1'b0;
        end
      endcase
    end
  end

endmodule

### rtl/rnci_mul.sv
// ----------------------------------------------------------------------------
// rnci_mul: shared multiplier unit
// Sign-magnitude 64 x 32 multiply built from two 32 x 32 partial products,
// the low slice first and the high slice added on top, then a finish step
// that shifts, truncates toward zero, saturates and restores the sign.
// ----------------------------------------------------------------------------
module rnci_mul #(
  parameter int ACC_WIDTH = rnci_pkg::ACC_WIDTH_DEF
) (
  input  logic                                clk,
  input  rnci_pkg::ctrl_t                     ctrl,
  input  logic signed [rnci_pkg::MAG_W-1:0]  opa,
  input  logic signed [rnci_pkg::COEF_W-1:0] opb,
  output logic signed [rnci_pkg::OUT_W-1:0]  fin
);
  import rnci_pkg::*;

  localparam logic [MAG_W-1:0] LIM_ACC = MAG_W'(1) << (ACC_WIDTH - 1);
  localparam logic [MAG_W-1:0] LIM_OUT = MAG_W'(1) << (OUT_W - 1);

  logic [MAG_W-1:0]  a_mag;
  logic [COEF_W-1:0] b_abs;
  logic [HALF_W-1:0] b_mag;
  logic [HALF_W-1:0] a_slice;
  logic [MAG_W-1:0]  pp;
  logic [PROD_W-1:0] prod;
  logic              neg;
  logic [PROD_W-1:0] shifted;
  logic [MAG_W-1:0]  lim;
  logic [MAG_W-1:0]  mag;

  // Operand magnitudes and the single 32 x 32 multiplier.
  always_comb begin
    a_mag   = opa[MAG_W-1] ? MAG_W'(-opa) : MAG_W'(opa);
    b_abs   = opb[COEF_W-1] ? COEF_W'(-opb) : COEF_W'(opb);
    b_mag   = b_abs[HALF_W-1:0];
    a_slice = (ctrl.mul_op == MUL_HI) ? a_mag[MAG_W-1:HALF_W] : a_mag[HALF_W-1:0];
    pp      = MAG_W'(a_slice) * MAG_W'(b_mag);
  end

  // Partial product accumulation; the sign is taken with the low slice.
  always_ff @(posedge clk) begin
    case (ctrl.mul_op)
      MUL_LO: begin
        prod <= PROD_W'(pp);
        neg  <= opa[MAG_W-1] ^ opb[COEF_W-1];
      end
      MUL_HI: begin
        prod <= prod + {pp, {HALF_W{1'b0}}};
      end
      default: begin
        prod <= prod;
      end
    endcase
  end

  // Shift, saturate to the target width and apply the sign.
  always_comb begin
    shifted = (ctrl.fin == FIN_ACC14) ? (prod >> SH_TERM) : (prod >> SH_PROD);
    lim     = ((ctrl.fin == FIN_OUT16) ? LIM_OUT : LIM_ACC) - {{(MAG_W-1){1'b0}}, ~neg};
    mag     = (shifted > PROD_W'(lim)) ? lim : shifted[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin != FIN_NONE) begin
      fin <= neg ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

### rtl/running_newton_cotes_integrator_unit.sv
// A sample that does not close a chunk keeps the unit busy for its term only;
// one that closes a chunk keeps it busy through the term, the total update,
// the scaled result and the opening term of the next chunk; its result is
// loaded into the output register after the total update, later if that
// register is held. A new sample is taken only while the unit is idle, since
// every product goes through the single shared 32 x 32 multiplier twice.
// Reset: synchronous; configuration registers take defaults, running sums clear.
// ----------------------------------------------------------------------------
// running_newton_cotes_integrator_unit: running composite Newton-Cotes integral
// Accumulates coefficient-weighted samples per chunk, folds each closed chunk
// into the total with the step size and emits the scaled, saturated total.
// ----------------------------------------------------------------------------
module running_newton_cotes_integrator_unit #(
  parameter int SAMPLE_WIDTH = rnci_pkg::SAMPLE_WIDTH_DEF,
  parameter int ACC_WIDTH    = rnci_pkg::ACC_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rnci_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rnci_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [rnci_pkg::OUT_W-1:0]      integral
);
  import rnci_pkg::*;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  // Configuration registers.
  logic [METHOD_W-1:0]          method;
  logic                         even_start;
  logic signed [CFG_DATA_W-1:0] step_size;
  logic signed [CFG_DATA_W-1:0] scale;

  // Integration state.
  logic [PHASE_W-1:0]           phase;
  logic [PHASE_W-1:0]           cur_phase;
  logic                         started;
  logic                         halve;
  logic                         close;
  logic signed [ACC_WIDTH-1:0]  chunk_sum;
  logic signed [ACC_WIDTH-1:0]  total;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;

  ctrl_t                        ctrl;
  stat_t                        stat;
  logic                         busy;
  logic                         start;
  logic [METHOD_W-1:0]          m_eff;
  logic [PHASE_W-1:0]           ps;
  logic                         even_go;

  logic signed [MAG_W-1:0]      opa;
  logic signed [COEF_W-1:0]     opb;
  logic signed [OUT_W-1:0]      fin;
  logic signed [ACC_WIDTH-1:0]  term;
  logic signed [ACC_WIDTH-1:0]  term_half;
  logic signed [ACC_WIDTH-1:0]  add_a;
  logic signed [ACC_WIDTH-1:0]  add_b;
  logic signed [ACC_WIDTH:0]    add_sum;
  logic signed [ACC_WIDTH-1:0]  add_res;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign start     = in_valid && in_ready;

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      method     <= METHOD_W'(1);
      even_start <= 1'b0;
      step_size  <= 32'sd65536;
      scale      <= 32'sd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_METHOD: method     <= cfg_data[METHOD_W-1:0];
        REG_EVEN:   even_start <= cfg_data[0];
        REG_STEP:   step_size  <= $signed(cfg_data);
        REG_SCALE:  scale      <= $signed(cfg_data);
        default:    method     <= method;
      endcase
    end
  end

  // Method clamped to the supported rules.
  always_comb begin
    if (method == '0) begin
      m_eff = METHOD_W'(1);
    end else if (method > METHOD_W'(8)) begin
      m_eff = METHOD_W'(8);
    end else begin
      m_eff = method;
    end
  end

  // Phase of an incoming sample; the very first one may start mid-chunk.
  always_comb begin
    even_go = !started && even_start && !m_eff[0];
    if (!started) begin
      ps = even_go ? PHASE_W'(m_eff >> 1) : '0;
    end else begin
      ps = (phase > PHASE_W'(m_eff)) ? PHASE_W'(m_eff) : phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      cur_phase <= '0;
      started   <= 1'b0;
      halve     <= 1'b0;
      close     <= 1'b0;
    end else if (start) begin
      started   <= 1'b1;
      cur_phase <= ps;
      halve     <= even_go;
      close     <= (ps == PHASE_W'(m_eff));
      phase     <= (ps == PHASE_W'(m_eff)) ? PHASE_W'(1) : ps + PHASE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sample_q <= sample;
    end
  end

  // Multiplier operand selection.
  always_comb begin
    case (ctrl.a_sel)
      A_CHUNK: opa = MAG_W'(chunk_sum);
      A_TOTAL: opa = MAG_W'(total);
      default: opa = MAG_W'(sample_q);
    endcase
    case (ctrl.b_sel)
      B_COEF0: opb = nc_coef(m_eff, '0);
      B_STEP:  opb = COEF_W'(step_size);
      B_SCALE: opb = COEF_W'(scale);
      default: opb = nc_coef(m_eff, cur_phase);
    endcase
  end

  rnci_mul #(
    .ACC_WIDTH(ACC_WIDTH)
  ) u_mul (
    .clk (clk),
    .ctrl(ctrl),
    .opa (opa),
    .opb (opb),
    .fin (fin)
  );

  // Saturating accumulate; the halved centre term truncates toward zero.
  always_comb begin
    term      = fin[ACC_WIDTH-1:0];
    term_half = $signed(term + ACC_WIDTH'(term[ACC_WIDTH-1])) >>> 1;
    add_a     = (ctrl.wb == WB_TOTAL_ADD) ? total : chunk_sum;
    add_b     = (ctrl.wb == WB_SUM_ADD && halve) ? term_half : term;
    add_sum   = {add_a[ACC_WIDTH-1], add_a} + {add_b[ACC_WIDTH-1], add_b};
    if (add_sum[ACC_WIDTH] != add_sum[ACC_WIDTH-1]) begin
      add_res = add_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      add_res = add_sum[ACC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_sum <= '0;
      total     <= '0;
    end else begin
      case (ctrl.wb)
        WB_SUM_ADD:   chunk_sum <= add_res;
        WB_SUM_LOAD:  chunk_sum <= term;
        WB_TOTAL_ADD: total     <= add_res;
        default:      total     <= total;
      endcase
    end
  end

  // Output register: holds a result beat until it is taken.
  assign stat.open     = !close;
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.wb == WB_OUT && stat.out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wb == WB_OUT && stat.out_free) begin
      integral <= fin;
    end
  end

  rnci_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .ctrl (ctrl),
    .busy (busy)
  );

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: running Newton-Cotes integrator check
// Streams Q16.16 samples through the integrator under a series of register
// settings. The bench keeps its own model of the chunk sums and the running
// total, and checks every integral beat against the predicted value. Both
// handshakes idle at random, and the output side is held off for a long time.
// ----------------------------------------------------------------------------
module testbench;
  import rnci_pkg::*;

  localparam int     SETTLE_CYCLES = 24;
  localparam int     TIMEOUT_TIME  = 2_000_000;
  localparam int     MAX_REPORTS   = 10;
  localparam int     TERM_SHIFT    = 14;
  localparam int     PRODUCT_SHIFT = 16;
  localparam longint ACC_MAX       = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN       = -ACC_MAX - 1;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [CFG_IDX_W-1:0]           cfg_index = '0;
  logic [CFG_DATA_W-1:0]          cfg_data  = '0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  logic signed [SAMPLE_WIDTH_DEF-1:0] sample = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic signed [OUT_W-1:0]        integral;

  // Integrator model: registers and running state, at their reset values.
  logic [3:0] method_q  = 4'd1;
  bit         even_q    = 1'b0;
  longint     step_q    = 65536;
  longint     scale_q   = 65536;
  int         phase_q   = 0;
  longint     chunk_q   = 0;
  longint     total_q   = 0;
  bit         started_q = 1'b0;

  longint expected_integrals[$];
  longint want;
  int     mismatch_count = 0;

  // Idling controls for both sides.
  int idle_pct   = 25;
  int stall_pct  = 25;
  int stall_left = 0;
  int hold_left  = 0;

  running_newton_cotes_integrator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .integral  (integral)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Closed Newton-Cotes weight in Q2.30 for point k of an m-interval rule,
  // rounded to nearest (ties away from zero) from the exact fraction.
  function automatic longint nc_weight(int m, int k);
    int     j;
    longint num;
    longint den;
    longint mag;
    // Every rule is symmetric about its centre point.
    j = (k > m / 2) ? m - k : k;
    num = 0;
    den = 1;
    case (m)
      1: begin
        num = 1;
        den = 2;
      end
      2: begin
        num = (j == 0) ? 1 : 4;
        den = 3;
      end
      3: begin
        num = (j == 0) ? 3 : 9;
        den = 8;
      end
      4: begin
        den = 45;
        case (j)
          0: num = 14;
          1: num = 64;
          default: num = 24;
        endcase
      end
      5: begin
        den = 288;
        case (j)
          0: num = 95;
          1: num = 375;
          default: num = 250;
        endcase
      end
      6: begin
        den = 140;
        case (j)
          0: num = 41;
          1: num = 216;
          2: num = 27;
          default: num = 272;
        endcase
      end
      7: begin
        den = 17280;
        case (j)
          0: num = 5257;
          1: num = 25039;
          2: num = 9261;
          default: num = 20923;
        endcase
      end
      default: begin
        den = 14175;
        case (j)
          0: num = 3956;
          1: num = 23552;
          2: num = -3712;
          3: num = 41984;
          default: num = -18160;
        endcase
      end
    endcase
    mag = (((num < 0 ? -num : num) << 30) + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  // Product shifted right, truncated toward zero and clamped to 64 bits.
  function automatic longint fixed_product(longint a, longint b, int sh);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] mag;
    logic [127:0] lim;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    mag = ({64'd0, ua} * {64'd0, ub}) >> sh;
    lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 128'd1);
    if (mag > lim) mag = lim;
    return neg ? -$signed(mag[63:0]) : $signed(mag[63:0]);
  endfunction

  function automatic longint sat_add(longint a, longint b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? ACC_MIN : ACC_MAX;
    return s[63:0];
  endfunction

  // Fold one accepted sample into the model; a closing sample queues a result.
  function automatic void integrate_sample(logic signed [31:0] v);
    int     m;
    bit     halve;
    longint s;
    longint term;
    m = (method_q < 4'd1) ? 1 : (method_q > 4'd8) ? 8 : int'(method_q);
    halve = 1'b0;
    s = v;
    // The even-function start is decided once, at the very first sample.
    if (!started_q) begin
      started_q = 1'b1;
      if (even_q && (m % 2 == 0)) begin
        phase_q = m / 2;
        halve = 1'b1;
      end else begin
        phase_q = 0;
      end
    end
    // A method shrunk mid-chunk closes the chunk at once.
    if (phase_q > m) phase_q = m;
    term = fixed_product(nc_weight(m, phase_q), s, TERM_SHIFT);
    if (halve) term = term / 2;
    chunk_q = sat_add(chunk_q, term);
    if (phase_q == m) begin
      total_q = sat_add(total_q, fixed_product(chunk_q, step_q, PRODUCT_SHIFT));
      expected_integrals.push_back(fixed_product(total_q, scale_q, PRODUCT_SHIFT));
      // The closing sample also opens the next chunk.
      chunk_q = fixed_product(nc_weight(m, 0), s, TERM_SHIFT);
      phase_q = 1;
    end else begin
      phase_q++;
    end
  endfunction

  function automatic logic signed [31:0] extreme_value();
    case ($urandom_range(4))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0000_0000;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(9))
      0: return extreme_value();
      1, 2: return $signed($urandom_range(131071)) - 32'sd65536;
      default: return $urandom;
    endcase
  endfunction

  // Step and scale stay moderate mostly, so the total does not pin at its rails.
  function automatic logic [31:0] rand_q16();
    case ($urandom_range(9))
      0: return $urandom;
      1: return extreme_value();
      default: return $signed($urandom_range(262143)) - 32'sd131072;
    endcase
  endfunction

  function automatic logic [3:0] rand_method();
    if ($urandom_range(6) == 0) return 4'($urandom_range(15));
    return 4'($urandom_range(8, 1));
  endfunction

  // Output side: random stall bursts, plus a long hold-off when one is asked.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(11, 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Each integral beat is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_integrals.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("integral beat with nothing predicted: got %h", integral);
      end else begin
        want = expected_integrals.pop_front();
        if (integral !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("integral mismatch: expected %h got %h", want, integral);
        end
      end
    end
  end

  // Offer one sample beat, after an optional idle burst, and wait for it.
  task automatic send_sample(logic signed [31:0] v);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= v;
    do @(posedge clk); while (!in_ready);
    integrate_sample(v);
  endtask

  // Stop offering samples, let all results drain and the unit go quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_integrals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_METHOD: method_q = data[3:0];
      REG_EVEN:   even_q = data[0];
      REG_STEP:   step_q = longint'($signed(data));
      REG_SCALE:  scale_q = longint'($signed(data));
      default: ;
    endcase
  endtask

  // Unused upper data bits carry noise that the unit must ignore.
  task automatic set_config(logic [3:0] m, bit ev, logic [31:0] st, logic [31:0] sc);
    wait_idle();
    write_reg(REG_METHOD, {28'($urandom), m});
    write_reg(REG_EVEN, {31'($urandom), ev});
    write_reg(REG_STEP, st);
    write_reg(REG_SCALE, sc);
    cfg_valid <= 1'b0;
  endtask

  // Even-function start: Simpson rule, first sample at the centre and halved.
  // An odd negative first sample checks that the halving truncates toward zero.
  task automatic test_even_start();
    set_config(4'd2, 1'b1, 32'h0001_0000, 32'h0001_0000);
    send_sample(-32'sd3);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sd0);
    send_sample(32'sd1);
    send_sample(-32'sd1);
  endtask

  // Methods out of range fold onto the trapezoid and the 8-interval rule.
  task automatic test_method_range();
    set_config(4'd0, 1'b0, 32'h0000_8000, 32'h0001_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    set_config(4'd5, 1'b1, 32'hFFFF_0000, 32'h0000_4000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    set_config(4'd9, 1'b0, 32'h0001_0000, 32'h0001_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    set_config(4'd15, 1'b0, 32'h0002_0000, 32'hFFFE_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
  endtask

  // Shrinking the method past the current point closes the chunk at once.
  task automatic test_mid_chunk_switch();
    set_config(4'd8, 1'b0, 32'h0000_4000, 32'h0002_0000);
    while (phase_q != 5) send_sample(rand_sample());
    set_config(4'd2, 1'b0, 32'h0000_4000, 32'h0002_0000);
    send_sample(32'sh0012_3456);
    send_sample(-32'sd77);
  endtask

  // Extreme step and scale drive the result into both rails.
  task automatic test_saturation();
    set_config(4'd1, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    repeat (3) send_sample(32'sh7FFF_FFFF);
    set_config(4'd1, 1'b0, 32'h8000_0000, 32'h8000_0000);
    repeat (3) send_sample(32'sh7FFF_FFFF);
  endtask

  // Random register settings, each followed by a run of random samples.
  task automatic test_random_phases();
    int p;
    int n;
    for (p = 0; p < 25; p++) begin
      set_config(rand_method(), 1'($urandom), rand_q16(), rand_q16());
      idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 5);
      stall_pct <= ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 5);
      n = $urandom_range(70, 30);
      repeat (n) send_sample(rand_sample());
    end
  endtask

  // Hold the output off long enough for the unit to stall its input, then
  // pause the input until every result has come back.
  task automatic test_output_hold();
    set_config(4'd1, 1'b0, 32'h0001_0000, 32'h0000_8000);
    idle_pct = 0;
    hold_left <= 300;
    repeat (40) send_sample(rand_sample());
    wait_idle();
    repeat (20) send_sample(rand_sample());
  endtask

  // Closing stretch with both sides streaming at full rate.
  task automatic test_steady_stream();
    set_config(rand_method(), 1'b0, rand_q16(), rand_q16());
    idle_pct = 0;
    stall_pct <= 0;
    repeat (300) send_sample(rand_sample());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_even_start();
    test_method_range();
    test_mid_chunk_switch();
    test_saturation();
    test_random_phases();
    test_output_hold();
    test_steady_stream();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("** running_newton_cotes_integrator_unit: PASSED **");
    end else begin
      $display("** running_newton_cotes_integrator_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_TIME);
    $display("** running_newton_cotes_integrator_unit: FAILED **");
    $finish;
  end

endmodule
